// ----- rtl/ilt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilt_pkg
// Shared types and codes of the indexed list table: item layouts of both
// channels, operation codes, status codes and default sizes.
// ---------------------------------------------------------------------------
package ilt_pkg;

    // Default sizes
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Operation codes
    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_GET    = 3'd1;
    localparam logic [2:0] FN_SET    = 3'd2;
    localparam logic [2:0] FN_REMOVE = 3'd3;
    localparam logic [2:0] FN_INSERT = 3'd4;
    localparam logic [2:0] FN_FIND   = 3'd5;
    localparam logic [2:0] FN_CLEAR  = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Request item
    typedef struct packed {
        logic [2:0]  func;
        logic [6:0]  index;
        logic [31:0] value;
    } ilt_in_t;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] element;
        logic        found;
        logic [5:0]  position;
        logic [6:0]  count;
        logic        empty_res;
    } ilt_out_t;

endpackage
`default_nettype wire

// ----- rtl/ilt_mem.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilt_mem
// Entry store of the list: one write port and one read port, read data
// registered.
// ---------------------------------------------------------------------------
module ilt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ilt_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ilt_ctrl
// Operation sequencer: checks each request, then walks the entry store one
// entry per cycle for remove, insert and find, streaming reads ahead of
// write-backs, and holds the length of the list.
// ---------------------------------------------------------------------------
module ilt_ctrl
    import ilt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int AW         = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request side
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire ilt_in_t               req,
    // result side
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output ilt_out_t                   res,
    // entry store
    output logic                       mem_we,
    output logic      [AW-1:0]         mem_waddr,
    output logic      [VALUE_BITS-1:0] mem_wdata,
    output logic                       mem_re,
    output logic      [AW-1:0]         mem_raddr,
    input  wire logic [VALUE_BITS-1:0] mem_rdata
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_FIND,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            func_reg, func_next;
    logic [6:0]            idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [LW-1:0]         ptr_reg, ptr_next;
    logic [LW-1:0]         wptr_reg, wptr_next;
    logic                  pend_reg, pend_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           elem_reg, elem_next;
    logic                  found_reg, found_next;
    logic [LW-1:0]         pos_reg, pos_next;

    logic [63:0]           vin_w;
    logic [63:0]           rd_w;
    logic [15:0]           pos_w;
    logic [15:0]           cnt_w;
    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         len_ext;
    logic [CW-1:0]         ptr_ext;
    logic [LW-1:0]         idx_l;
    logic [LW-1:0]         ptr_dec;
    logic                  v_zero;
    logic                  full;
    logic                  idx_lt;
    logic                  idx_le;
    logic                  idx_eq;
    logic                  ptr_lt_len;

    // Fit widths between the fixed fields and the stored entries
    assign vin_w      = 64'(req.value);
    assign rd_w       = 64'(mem_rdata);
    assign pos_w      = 16'(pos_reg);
    assign cnt_w      = 16'(len_reg);
    assign idx_ext    = CW'(idx_reg);
    assign len_ext    = CW'(len_reg);
    assign ptr_ext    = CW'(ptr_reg);
    assign idx_l      = LW'(idx_ext);
    assign ptr_dec    = ptr_reg - LW'(1);

    // Request checks
    assign v_zero     = (val_reg == '0);
    assign full       = (len_reg == LW'(CAPACITY));
    assign idx_lt     = (idx_ext < len_ext);
    assign idx_le     = (idx_ext <= len_ext);
    assign idx_eq     = (idx_ext == len_ext);
    assign ptr_lt_len = (ptr_reg < len_reg);

    // Handshake and result
    assign req_ready     = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_FINISH);
    assign res.status    = status_reg;
    assign res.element   = elem_reg;
    assign res.found     = found_reg;
    assign res.position  = pos_w[5:0];
    assign res.count     = cnt_w[6:0];
    assign res.empty_res = (len_reg == '0);

    // Sequence the operation
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        wptr_next   = wptr_reg;
        pend_next   = pend_reg;
        status_next = status_reg;
        elem_next   = elem_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // take a new item and clear the result fields
                if (req_valid)
                begin
                    func_next   = req.func;
                    idx_next    = req.index;
                    val_next    = vin_w[VALUE_BITS-1:0];
                    status_next = ST_OK;
                    elem_next   = '0;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FINISH;
                unique case (func_reg)
                    FN_APPEND:
                    begin
                        if (v_zero)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = len_reg[AW-1:0];
                            mem_wdata = val_reg;
                            len_next  = len_reg + LW'(1);
                        end
                    end
                    FN_GET:
                    begin
                        if (!idx_lt)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = idx_ext[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                    FN_SET:
                    begin
                        if (v_zero || !idx_le)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (idx_eq && full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_ext[AW-1:0];
                            mem_wdata = val_reg;
                            if (idx_eq)
                            begin
                                len_next = len_reg + LW'(1);
                            end
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (!idx_lt)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = idx_ext[AW-1:0];
                            ptr_next   = idx_l + LW'(1);
                            state_next = S_READ;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (v_zero || !idx_le)
                        begin
                            status_next = ST_BAD;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ptr_next   = len_reg;
                            wptr_next  = len_reg;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    FN_FIND:
                    begin
                        if (v_zero)
                        begin
                            status_next = ST_BAD;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_FIND;
                        end
                    end
                    FN_CLEAR:
                    begin
                        len_next = '0;
                    end
                    default:
                    begin
                        status_next = ST_BAD;
                    end
                endcase
            end

            S_READ:
            begin
                // capture the addressed entry; remove goes on to close the gap
                elem_next = rd_w[31:0];
                if (func_reg == FN_REMOVE)
                begin
                    wptr_next  = idx_l;
                    pend_next  = 1'b0;
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_SHIFT_DN:
            begin
                // write back the previous read one place lower
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    wptr_next = wptr_reg + LW'(1);
                end
                // read ahead while entries remain above
                if (ptr_lt_len)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + LW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        len_next   = len_reg - LW'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_SHIFT_UP:
            begin
                // drain: drop the new value into the freed slot
                if (!pend_reg && !(ptr_ext > idx_ext))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_ext[AW-1:0];
                    mem_wdata  = val_reg;
                    len_next   = len_reg + LW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    // write back the previous read one place higher
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wptr_reg[AW-1:0];
                        mem_wdata = mem_rdata;
                        wptr_next = wptr_reg - LW'(1);
                    end
                    // read downward toward the insert position
                    if (ptr_ext > idx_ext)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_dec[AW-1:0];
                        ptr_next  = ptr_dec;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            S_FIND:
            begin
                // compare the previous read, stop at the first hit
                priority if (pend_reg && (mem_rdata == val_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = wptr_reg;
                    state_next = S_FINISH;
                end
                else if (ptr_lt_len)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    wptr_next = ptr_reg;
                    ptr_next  = ptr_reg + LW'(1);
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // hold the result until the output stage takes it
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
            func_reg   <= '0;
            idx_reg    <= '0;
            val_reg    <= '0;
            ptr_reg    <= '0;
            wptr_reg   <= '0;
            status_reg <= ST_OK;
            elem_reg   <= '0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
            func_reg   <= func_next;
            idx_reg    <= idx_next;
            val_reg    <= val_next;
            ptr_reg    <= ptr_next;
            wptr_reg   <= wptr_next;
            status_reg <= status_next;
            elem_reg   <= elem_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/indexed_list_table.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_list_table
// Bounded ordered list of non-zero element handles held in one entry store.
//
// Requests arrive on in_item under in_valid/in_ready; each gives exactly one
// result on out_item under out_valid/out_ready, in request order.
// Remove, insert and find walk the store one entry per cycle through its
// single registered read port. One request is in work at a time; the
// next is taken in the cycle after the result enters the output register,
// so a waiting result does not hold off the next request.
// Reset empties the list (count 0); entry contents are left as they are.
// When the receiver stalls, the result is held in the output register and a
// second finished result waits in the sequencer until the register frees.
// ---------------------------------------------------------------------------
module indexed_list_table
    import ilt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire ilt_in_t in_item,
    output logic         out_valid,
    input  wire logic    out_ready,
    output ilt_out_t     out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                  res_valid;
    logic                  res_ready;
    ilt_out_t              res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  out_valid_reg, out_valid_next;
    ilt_out_t              out_item_reg, out_item_next;

    ilt_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ilt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire

// ----- dv/tb_indexed_list_table.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb_indexed_list_table
// Self-checking bench for the indexed list table. A shadow copy of the list
// predicts status, element, find position and count for every accepted
// request. A short directed run covers the edges: empty list, zero values,
// bad indexes and the unused code. Random phases that grow, shrink, mix or
// scramble the list follow. Both handshakes see random idle bursts except
// in the closing phase.
// ---------------------------------------------------------------------------
module tb_indexed_list_table;
    import ilt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS  = 200;
    localparam int DRAIN_CYCLES = CAPACITY_DEF + 16;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} mix_t;

    // Shadow list: predicts each result and holds the results still owed
    class list_tracker;
        logic [31:0]  slots [CAPACITY_DEF];
        int unsigned  fill;
        ilt_out_t     owed_results [$];
        int unsigned  failures;

        function new();
            fill = 0;
            failures = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        // Open a hole at pos and place v there
        function logic [1:0] place_at(int unsigned pos, logic [31:0] v);
            if (fill >= CAPACITY_DEF)
                return ST_FULL;
            for (int unsigned i = fill; i > pos; i--)
                slots[i] = slots[i - 1];
            slots[pos] = v;
            fill++;
            return ST_OK;
        endfunction

        function ilt_out_t apply_request(ilt_in_t req);
            ilt_out_t res;
            res = '0;
            case (req.func)
                FN_APPEND:
                    if (req.value == '0) res.status = ST_BAD;
                    else res.status = place_at(fill, req.value);
                FN_GET:
                    if (req.index >= fill) res.status = ST_BAD;
                    else res.element = slots[req.index];
                FN_SET:
                    if (req.value == '0 || req.index > fill) res.status = ST_BAD;
                    else if (req.index == fill) res.status = place_at(fill, req.value);
                    else slots[req.index] = req.value;
                FN_REMOVE:
                    if (req.index >= fill) begin
                        res.status = ST_BAD;
                    end
                    else begin
                        res.element = slots[req.index];
                        for (int unsigned i = req.index; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                FN_INSERT:
                    if (req.value == '0 || req.index > fill) res.status = ST_BAD;
                    else res.status = place_at(req.index, req.value);
                FN_FIND:
                    if (req.value == '0) begin
                        res.status = ST_BAD;
                    end
                    else begin
                        for (int unsigned i = 0; i < fill; i++)
                            if (!res.found && slots[i] == req.value) begin
                                res.found = 1'b1;
                                res.position = 6'(i);
                            end
                    end
                FN_CLEAR:
                    fill = 0;
                default:
                    res.status = ST_BAD;
            endcase
            res.count = 7'(fill);
            res.empty_res = (fill == 0);
            return res;
        endfunction

        function void note_request(ilt_in_t req);
            owed_results.push_back(apply_request(req));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            end
        endfunction

        function void check_result(ilt_out_t got);
            ilt_out_t want;
            if (owed_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("element", want.element, got.element);
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("position", 32'(want.position), 32'(got.position));
            compare_field("count", 32'(want.count), 32'(got.count));
            compare_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    ilt_in_t  in_item = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    ilt_out_t out_item;

    list_tracker shadow = new();
    int unsigned in_gap_pct = 20;
    int unsigned out_stall_pct = 20;
    int unsigned cycles = 0;

    indexed_list_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bound the run; otherwise check every delivered result
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[indexed_list_table] ERROR");
            $finish;
        end
        else if (rst_n && out_valid && out_ready) begin
            shadow.check_result(out_item);
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        while (!rst_n) @(posedge clk);
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 99) < out_stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    function automatic ilt_in_t make_req(logic [2:0] func, logic [6:0] index,
                                         logic [31:0] value);
        ilt_in_t req;
        req.func = func;
        req.index = index;
        req.value = value;
        return req;
    endfunction

    // Build one request weighted toward the given mix
    function automatic ilt_in_t pick_request(mix_t mix);
        ilt_in_t req;
        int unsigned n;
        int unsigned roll;
        int unsigned span;
        n = shadow.fill;
        roll = $urandom_range(0, 99);
        if (mix == MIX_NOISE) begin
            req.func = 3'($urandom_range(0, 7));
            req.index = 7'($urandom_range(0, 127));
            req.value = (roll < 30) ? 32'h0 : 32'($urandom);
            return req;
        end
        case (mix)
            MIX_GROW:
                req.func = (roll < 45) ? FN_APPEND : (roll < 65) ? FN_INSERT :
                           (roll < 75) ? FN_SET : (roll < 85) ? FN_GET :
                           (roll < 95) ? FN_FIND : FN_REMOVE;
            MIX_SHRINK:
                req.func = (roll < 45) ? FN_REMOVE : (roll < 60) ? FN_GET :
                           (roll < 75) ? FN_FIND : (roll < 85) ? FN_APPEND :
                           (roll < 95) ? FN_SET : FN_INSERT;
            default:
                req.func = (roll < 16) ? FN_APPEND : (roll < 30) ? FN_GET :
                           (roll < 44) ? FN_SET : (roll < 60) ? FN_REMOVE :
                           (roll < 76) ? FN_INSERT : (roll < 98) ? FN_FIND : FN_CLEAR;
        endcase

        // Index: mostly legal, with the boundary and wild values mixed in
        span = (req.func == FN_SET || req.func == FN_INSERT) ? n : ((n > 0) ? n - 1 : 0);
        roll = $urandom_range(0, 99);
        if (roll < 70) req.index = 7'($urandom_range(0, span));
        else if (roll < 80) req.index = 7'(n);
        else if (roll < 88) req.index = '0;
        else if (roll < 94) req.index = 7'(span);
        else req.index = 7'($urandom_range(0, 127));

        // Value: reuse stored handles often so find hits
        roll = $urandom_range(0, 99);
        if (roll < 4) req.value = '0;
        else if (roll < 40 && n > 0) req.value = shadow.slots[$urandom_range(0, n - 1)];
        else if (roll < 50) req.value = 32'($urandom_range(1, 8));
        else if (roll < 53) req.value = 32'hFFFF_FFFF;
        else req.value = 32'($urandom);
        return req;
    endfunction

    // Present one item, hold it until taken, then record it
    task automatic send_request(ilt_in_t req);
        if ($urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (!in_ready);
        shadow.note_request(req);
    endtask

    initial
    begin
        int unsigned issued;
        int unsigned seg_len;
        int unsigned roll;
        mix_t mix;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edge cases on a small list
        send_request(make_req(FN_CLEAR, 7'd0, 32'h0));
        send_request(make_req(FN_GET, 7'd0, 32'h0));
        send_request(make_req(FN_REMOVE, 7'd0, 32'h0));
        send_request(make_req(FN_FIND, 7'd0, 32'h5));
        send_request(make_req(FN_APPEND, 7'd0, 32'h0));
        send_request(make_req(FN_APPEND, 7'd0, 32'hFFFF_FFFF));
        send_request(make_req(FN_APPEND, 7'd0, 32'h1));
        send_request(make_req(FN_SET, 7'd2, 32'h8000_0000));
        send_request(make_req(FN_SET, 7'd4, 32'h3));
        send_request(make_req(FN_SET, 7'd1, 32'h0));
        send_request(make_req(FN_SET, 7'd1, 32'h1234_5678));
        send_request(make_req(FN_INSERT, 7'd0, 32'hA5A5_A5A5));
        send_request(make_req(FN_INSERT, 7'd4, 32'h7));
        send_request(make_req(FN_INSERT, 7'd6, 32'h9));
        send_request(make_req(FN_INSERT, 7'd1, 32'h0));
        send_request(make_req(FN_GET, 7'd0, 32'h0));
        send_request(make_req(FN_GET, 7'd4, 32'h0));
        send_request(make_req(FN_GET, 7'd5, 32'h0));
        send_request(make_req(FN_GET, 7'd127, 32'hFFFF_FFFF));
        send_request(make_req(FN_FIND, 7'd0, 32'h8000_0000));
        send_request(make_req(FN_FIND, 7'd0, 32'hDEAD_BEEF));
        send_request(make_req(FN_FIND, 7'd0, 32'h0));
        send_request(make_req(FN_REMOVE, 7'd2, 32'h0));
        send_request(make_req(FN_REMOVE, 7'd0, 32'h0));
        send_request(make_req(FN_REMOVE, 7'd2, 32'h0));
        send_request(make_req(3'd7, 7'd127, 32'hFFFF_FFFF));
        send_request(make_req(FN_CLEAR, 7'd64, 32'h0));

        // Random phases; growth phases run long enough to fill the list
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            mix = (roll < 35) ? MIX_GROW : (roll < 60) ? MIX_SHRINK :
                  (roll < 90) ? MIX_BALANCED : MIX_NOISE;
            seg_len = (mix == MIX_GROW) ? $urandom_range(60, 160) : $urandom_range(20, 100);
            if (issued + QUIET_ITEMS >= RANDOM_ITEMS) begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end
            else begin
                in_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
                out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            repeat (seg_len) begin
                send_request(pick_request(mix));
                issued++;
            end
        end
        in_valid <= 1'b0;

        // Drain the owed results, then let any late extra result show up
        while (shadow.owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.failures == 0)
            $display("[indexed_list_table] OK");
        else
            $display("[indexed_list_table] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
